>>> src/mrtu_pkg.sv
// shared types and the high-half code point table for the mac roman transcoder
package mrtu_pkg;

	// code point of mac roman bytes 0x80 to 0xff, indexed by the low seven bits
	localparam logic [15:0] HIGH_HALF_MAP [128] = '{
		16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
		16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
		16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
		16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
		16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
		16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
		16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
		16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
		16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
		16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
		16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
		16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
		16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
		16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
		16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
		16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
	};

	// largest code point that fits a two-byte utf-8 sequence
	localparam logic [15:0] UTF8_TWO_MAX = 16'h07FF;

	// lead and continuation byte marks
	localparam logic [2:0] LEAD2_MARK = 3'b110;
	localparam logic [3:0] LEAD3_MARK = 4'b1110;
	localparam logic [1:0] CONT_MARK  = 2'b10;

	// number of units an item produces
	localparam logic [1:0] UNITS_ONE   = 2'd1;
	localparam logic [1:0] UNITS_TWO   = 2'd2;
	localparam logic [1:0] UNITS_THREE = 2'd3;

	// output form selected by the mode register
	localparam logic MODE_UTF8 = 1'b0;

	// code point after lookup
	typedef struct packed {
		logic [15:0] cp;
		logic        single;
	} cp_item_t;

	// encoded units of one request
	typedef struct packed {
		logic [15:0] u0;
		logic [15:0] u1;
		logic [15:0] u2;
		logic [1:0]  cnt;
	} enc_item_t;

endpackage

>>> src/mrtu_lookup.sv
// input register and table lookup stages of the transcoder
module mrtu_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              mode,
	output logic              item_valid,
	input  logic              item_ready,
	output mrtu_pkg::cp_item_t item
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       mode_s1;
	logic       v_s2;
	mrtu_pkg::cp_item_t item_s2;
	logic       rdy_s1;
	logic       rdy_s2;

	// a stage moves when it is empty or its successor takes its content
	assign rdy_s2   = !v_s2 || item_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			byte_s1 <= in_byte;
			mode_s1 <= mode;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	// stage 2 payload: ascii passes, high half goes through the table
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			if (!byte_s1[7]) begin
				item_s2.cp <= {8'h00, byte_s1};
			end else begin
				item_s2.cp <= mrtu_pkg::HIGH_HALF_MAP[byte_s1[6:0]];
			end
			item_s2.single <= !byte_s1[7] || (mode_s1 != mrtu_pkg::MODE_UTF8);
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

>>> src/mrtu_encode.sv
// utf-8 encoding stage of the transcoder
module mrtu_encode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mrtu_pkg::cp_item_t  item,
	output logic                enc_valid,
	input  logic                enc_ready,
	output mrtu_pkg::enc_item_t enc
);

	logic                v_s3;
	mrtu_pkg::enc_item_t enc_s3;
	mrtu_pkg::enc_item_t enc_d;
	logic                rdy_s3;

	assign rdy_s3     = !v_s3 || enc_ready;
	assign item_ready = rdy_s3;

	// split the code point into one, two or three units
	always_comb begin
		enc_d.u0  = item.cp;
		enc_d.u1  = '0;
		enc_d.u2  = '0;
		enc_d.cnt = mrtu_pkg::UNITS_ONE;
		if (!item.single) begin
			if (item.cp <= mrtu_pkg::UTF8_TWO_MAX) begin
				enc_d.u0  = {8'h00, mrtu_pkg::LEAD2_MARK, item.cp[10:6]};
				enc_d.u1  = {8'h00, mrtu_pkg::CONT_MARK, item.cp[5:0]};
				enc_d.cnt = mrtu_pkg::UNITS_TWO;
			end else begin
				enc_d.u0  = {8'h00, mrtu_pkg::LEAD3_MARK, item.cp[15:12]};
				enc_d.u1  = {8'h00, mrtu_pkg::CONT_MARK, item.cp[11:6]};
				enc_d.u2  = {8'h00, mrtu_pkg::CONT_MARK, item.cp[5:0]};
				enc_d.cnt = mrtu_pkg::UNITS_THREE;
			end
		end
	end

	// stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= item_valid;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (rdy_s3 && item_valid) begin
			enc_s3 <= enc_d;
		end
	end

	assign enc_valid = v_s3;
	assign enc       = enc_s3;

endmodule

>>> src/mrtu_serializer.sv
// output stage that hands out the encoded units one per cycle while out_ready is high
module mrtu_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enc_valid,
	output logic                enc_ready,
	input  mrtu_pkg::enc_item_t enc,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         out_unit,
	output logic                last_unit
);

	logic        v_q;
	logic [1:0]  cnt_q;
	logic [15:0] u0_q;
	logic [15:0] u1_q;
	logic [15:0] u2_q;
	logic        take;
	logic        load;
	logic        on_last;

	assign on_last   = (cnt_q == mrtu_pkg::UNITS_ONE);
	assign take      = v_q && out_ready;
	assign enc_ready = !v_q || (take && on_last);
	assign load      = enc_valid && enc_ready;

	// occupancy and remaining unit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			cnt_q <= 2'd0;
		end else if (load) begin
			v_q   <= 1'b1;
			cnt_q <= enc.cnt;
		end else if (take) begin
			v_q   <= !on_last;
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// unit shift register, head is on the port
	always_ff @(posedge clk) begin
		if (load) begin
			u0_q <= enc.u0;
			u1_q <= enc.u1;
			u2_q <= enc.u2;
		end else if (take) begin
			u0_q <= u1_q;
			u1_q <= u2_q;
		end
	end

	assign out_valid = v_q;
	assign out_unit  = u0_q;
	assign last_unit = on_last;

	// a held request always has units left
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> (cnt_q != 2'd0))
		else $error("serializer holds a request with no units left");

	// a unit that is not the last one is followed by another
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !on_last) |=> v_q)
		else $error("serializer dropped units of a request");

	// the next unit is the one queued behind the head
	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !on_last) |=> (out_unit == $past(u1_q)))
		else $error("serializer unit order broken");

	// nothing shows after the last unit unless a new request loaded
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && on_last && !load) |=> !v_q)
		else $error("serializer repeated a request");

endmodule

>>> src/mac_roman_to_unicode_transcoder_unit.sv
// top level of the mac roman to unicode transcoder
// Converts one Mac Roman byte per request into UTF-8 bytes (cfg write 0, the
// reset default) or one 16-bit code unit (cfg write 1). ASCII bytes always give
// a single unit; high-half bytes in UTF-8 mode give two or three units, the final
// one flagged by last_unit. A request passes an input register, a table lookup
// stage and an encode stage, then an output register that hands out one unit per
// cycle while out_ready is high, so a request holds the output until all of its
// one to three units are taken. Single-unit traffic flows at one request per
// cycle while out_ready is high; the one-unit output port makes a multi-unit request hold back the next.
// Change the mode only while the block is empty.
module mac_roman_to_unicode_transcoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_unit,
	output logic        last_unit
);

	logic                output_mode_q;
	logic                item_valid;
	logic                item_ready;
	mrtu_pkg::cp_item_t  item;
	logic                enc_valid;
	logic                enc_ready;
	mrtu_pkg::enc_item_t enc;

	// mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_mode_q <= mrtu_pkg::MODE_UTF8;
		end else if (cfg_valid && cfg_ready) begin
			output_mode_q <= cfg_data;
		end
	end

	// input register and table lookup
	mrtu_lookup u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.mode       (output_mode_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// utf-8 encoding
	mrtu_encode u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.enc_valid  (enc_valid),
		.enc_ready  (enc_ready),
		.enc        (enc)
	);

	// unit output
	mrtu_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_valid (enc_valid),
		.enc_ready (enc_ready),
		.enc       (enc),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_unit  (out_unit),
		.last_unit (last_unit)
	);

endmodule
